>>> rtl/servo_joint_jog_limiter_assert.svh
// Assertion macros for the servo joint jog limiter.
// Used by the top level; expects clk and arst_n in scope.
`ifndef SERVO_JOINT_JOG_LIMITER_ASSERT_SVH
`define SERVO_JOINT_JOG_LIMITER_ASSERT_SVH

`ifndef SYNTHESIS
`define SJJL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sjjl assertion failed");
`define SJJL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sjjl assertion failed");
`else
`define SJJL_ASSERT_NOW(label, ante, cons)
`define SJJL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/sjjl_pkg.sv
// Package for the servo joint jog limiter: types, codes and reset values.
// No dependencies.
`default_nettype none

package sjjl_pkg;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_CW   = 2'd1,
		DIR_CCW  = 2'd2
	} dir_t;

	typedef enum logic [2:0] {
		REG_STICK_MODE  = 3'd0,
		REG_POS_IS_CW   = 3'd1,
		REG_DEAD_ZONE   = 3'd2,
		REG_ANGLE_MIN   = 3'd3,
		REG_ANGLE_MAX   = 3'd4,
		REG_STEP_SIZE   = 3'd5,
		REG_START_ANGLE = 3'd6
	} reg_idx_t;

	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 15;

	localparam logic        RST_STICK_MODE  = 1'b0;
	localparam logic        RST_POS_IS_CW   = 1'b1;
	localparam logic [14:0] RST_DEAD_ZONE   = 15'd7500;
	localparam logic [7:0]  RST_ANGLE_MIN   = 8'd0;
	localparam logic [7:0]  RST_ANGLE_MAX   = 8'd180;
	localparam logic [7:0]  RST_STEP_SIZE   = 8'd5;
	localparam logic [7:0]  RST_START_ANGLE = 8'd90;

	typedef struct packed {
		logic        stick_mode;
		logic        positive_is_clockwise;
		logic [14:0] dead_zone;
		logic [7:0]  angle_min;
		logic [7:0]  angle_max;
		logic [7:0]  step_size;
	} cfg_t;

	typedef struct packed {
		logic               action;
		logic signed [15:0] stick_value;
		logic               cw_button;
		logic               ccw_button;
		logic [1:0]         move_direction;
		logic [7:0]         move_angle;
		logic               interlock_ok;
	} cmd_t;

	typedef struct packed {
		logic [7:0] position;
		logic       moved;
		dir_t       direction_taken;
		logic       clamped;
	} rsp_t;

endpackage

`default_nettype wire

>>> rtl/sjjl_if.sv
// Channel interfaces for the servo joint jog limiter: command, result, config.
// Depends on sjjl_pkg for the config field widths.
`default_nettype none

interface sjjl_cmd_if;
	logic               valid;
	logic               ready;
	logic               action;
	logic signed [15:0] stick_value;
	logic               cw_button;
	logic               ccw_button;
	logic [1:0]         move_direction;
	logic [7:0]         move_angle;
	logic               interlock_ok;
	modport source (output valid, action, stick_value, cw_button, ccw_button,
		move_direction, move_angle, interlock_ok, input ready);
	modport sink (input valid, action, stick_value, cw_button, ccw_button,
		move_direction, move_angle, interlock_ok, output ready);
endinterface

interface sjjl_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] position;
	logic       moved;
	logic [1:0] direction_taken;
	logic       clamped;
	modport source (output valid, position, moved, direction_taken, clamped,
		input ready);
	modport sink (input valid, position, moved, direction_taken, clamped,
		output ready);
endinterface

interface sjjl_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [sjjl_pkg::REG_IDX_W-1:0]   reg_index;
	logic [sjjl_pkg::CFG_DATA_W-1:0]  wdata;
	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

>>> rtl/servo_joint_jog_limiter.sv
// Servo joint jog limiter: keeps one joint angle and steps or moves it per command.
// A command is registered in stage 1, and its result in stage 2, which drives rsp.
// Throughput: one command per cycle when rsp is not stalling; each command sees the prior angle.
// Reset: config registers take their defaults, the angle loads 90, both stages empty.
// Depends on sjjl_pkg, sjjl_if, sjjl_step and servo_joint_jog_limiter_assert.svh.
`default_nettype none
`include "servo_joint_jog_limiter_assert.svh"

module servo_joint_jog_limiter (
	input  wire        clk,
	input  wire        arst_n,
	sjjl_cmd_if.sink   cmd,
	sjjl_rsp_if.source rsp,
	sjjl_cfg_if.sink   cfg
);
	import sjjl_pkg::*;

	cfg_t       cfg_q;
	logic [7:0] angle_q;
	logic       v_s1;
	cmd_t       cmd_s1;
	logic       v_s2;
	rsp_t       rsp_s2;
	rsp_t       step_rsp;
	cmd_t       cmd_in;
	logic       adv_s2;
	logic       load_s2;
	logic       cmd_xfer;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stick_mode            <= RST_STICK_MODE;
			cfg_q.positive_is_clockwise <= RST_POS_IS_CW;
			cfg_q.dead_zone             <= RST_DEAD_ZONE;
			cfg_q.angle_min             <= RST_ANGLE_MIN;
			cfg_q.angle_max             <= RST_ANGLE_MAX;
			cfg_q.step_size             <= RST_STEP_SIZE;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.reg_index))
				REG_STICK_MODE: cfg_q.stick_mode <= cfg.wdata[0];
				REG_POS_IS_CW:  cfg_q.positive_is_clockwise <= cfg.wdata[0];
				REG_DEAD_ZONE:  cfg_q.dead_zone <= cfg.wdata;
				REG_ANGLE_MIN:  cfg_q.angle_min <= cfg.wdata[7:0];
				REG_ANGLE_MAX:  cfg_q.angle_max <= cfg.wdata[7:0];
				REG_STEP_SIZE:  cfg_q.step_size <= cfg.wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	assign adv_s2    = !v_s2 || rsp.ready;
	assign load_s2   = v_s1 && adv_s2;
	assign cmd.ready = !v_s1 || adv_s2;
	assign cmd_xfer  = cmd.valid && cmd.ready;

	assign cmd_in.action         = cmd.action;
	assign cmd_in.stick_value    = cmd.stick_value;
	assign cmd_in.cw_button      = cmd.cw_button;
	assign cmd_in.ccw_button     = cmd.ccw_button;
	assign cmd_in.move_direction = cmd.move_direction;
	assign cmd_in.move_angle     = cmd.move_angle;
	assign cmd_in.interlock_ok   = cmd.interlock_ok;

	sjjl_step u_step (
		.cfg   (cfg_q),
		.cmd   (cmd_s1),
		.angle (angle_q),
		.rsp   (step_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			angle_q <= RST_START_ANGLE;
		end else begin
			if (cmd.ready) begin
				v_s1 <= cmd.valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (load_s2) begin
				angle_q <= step_rsp.position;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			cmd_s1 <= cmd_in;
		end
		if (load_s2) begin
			rsp_s2 <= step_rsp;
		end
	end

	assign rsp.valid           = v_s2;
	assign rsp.position        = rsp_s2.position;
	assign rsp.moved           = rsp_s2.moved;
	assign rsp.direction_taken = rsp_s2.direction_taken;
	assign rsp.clamped         = rsp_s2.clamped;

	`SJJL_ASSERT_NEXT(a_angle_only_on_load, !load_s2, angle_q == $past(angle_q))
	`SJJL_ASSERT_NOW(a_result_matches_angle, v_s2, rsp_s2.position == angle_q)
	`SJJL_ASSERT_NEXT(a_stage1_kept_on_stall, v_s1 && !adv_s2, v_s1 && $stable(cmd_s1))
	`SJJL_ASSERT_NOW(a_moved_needs_dir, v_s2 && rsp_s2.moved, rsp_s2.direction_taken != DIR_NONE)

endmodule

`default_nettype wire

>>> rtl/sjjl_step.sv
// Next-angle logic: direction decode, limit checks and clamping for one item.
// Depends on sjjl_pkg.
`default_nettype none

module sjjl_step (
	input  wire sjjl_pkg::cfg_t cfg,
	input  wire sjjl_pkg::cmd_t cmd,
	input  wire [7:0]           angle,
	output sjjl_pkg::rsp_t      rsp
);
	import sjjl_pkg::*;

	logic        neg;
	logic [16:0] mag;
	dir_t        jog_dir;
	dir_t        dir;
	logic [7:0]  next_angle;
	logic        clamped;
	logic [8:0]  up_sum;
	logic [8:0]  step_floor;
	logic [8:0]  move_sum;
	logic [8:0]  move_floor;

	assign neg = cmd.stick_value[15];
	assign mag = neg ? (17'h10000 - {1'b0, cmd.stick_value}) : {1'b0, cmd.stick_value};

	always_comb begin
		jog_dir = DIR_NONE;
		if (cfg.stick_mode) begin
			if (mag > {2'b00, cfg.dead_zone}) begin
				jog_dir = (neg ^ cfg.positive_is_clockwise) ? DIR_CW : DIR_CCW;
			end
		end else if (cmd.cw_button && !cmd.ccw_button) begin
			jog_dir = DIR_CW;
		end else if (cmd.ccw_button && !cmd.cw_button) begin
			jog_dir = DIR_CCW;
		end
	end

	assign up_sum     = {1'b0, angle} + {1'b0, cfg.step_size};
	assign step_floor = {1'b0, cfg.angle_min} + {1'b0, cfg.step_size};
	assign move_sum   = {1'b0, angle} + {1'b0, cmd.move_angle};
	assign move_floor = {1'b0, cfg.angle_min} + {1'b0, cmd.move_angle};

	always_comb begin
		next_angle = angle;
		clamped    = 1'b0;
		dir        = DIR_NONE;
		if (!cmd.action) begin
			dir = jog_dir;
			case (jog_dir)
				DIR_CW: begin
					if (up_sum > {1'b0, cfg.angle_max} || !cmd.interlock_ok) begin
						clamped = 1'b1;
					end else begin
						next_angle = up_sum[7:0];
					end
				end
				DIR_CCW: begin
					if ({1'b0, angle} < step_floor || !cmd.interlock_ok) begin
						clamped = 1'b1;
					end else begin
						next_angle = angle - cfg.step_size;
					end
				end
				default: begin
				end
			endcase
		end else begin
			case (cmd.move_direction)
				DIR_CW: begin
					dir = DIR_CW;
					if (move_sum < {1'b0, cfg.angle_max}) begin
						next_angle = move_sum[7:0];
					end else begin
						clamped = 1'b1;
						if (angle < cfg.angle_max) begin
							next_angle = cfg.angle_max;
						end
					end
				end
				DIR_CCW: begin
					dir = DIR_CCW;
					if ({1'b0, angle} > move_floor) begin
						next_angle = angle - cmd.move_angle;
					end else begin
						clamped = 1'b1;
						if (angle > cfg.angle_min) begin
							next_angle = cfg.angle_min;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign rsp.position        = next_angle;
	assign rsp.moved           = (next_angle != angle);
	assign rsp.direction_taken = dir;
	assign rsp.clamped         = clamped;

endmodule

`default_nettype wire

>>> sim/servo_joint_jog_limiter_test.sv
// Self-checking testbench for servo_joint_jog_limiter: directed and random commands
// with random stalls, checked against an in-bench prediction of the joint angle.
// Depends on sjjl_pkg, sjjl_if and the servo_joint_jog_limiter RTL.
`timescale 1ns / 1ps

module servo_joint_jog_limiter_test;
	import sjjl_pkg::*;

	localparam logic       ACT_JOG          = 1'b0;
	localparam logic       ACT_MOVE         = 1'b1;
	localparam logic [1:0] DIR_CODE_INVALID = 2'd3;
	localparam int         HOLD_CYCLES      = 60;
	localparam int         SETTLE_CYCLES    = 4;
	localparam int         WATCHDOG_CYCLES  = 1000;
	localparam int         RANDOM_PHASES    = 10;
	localparam int         PHASE_ITEMS      = 95;

	logic clk;
	logic arst_n;

	sjjl_cmd_if cmd_ch ();
	sjjl_rsp_if rsp_ch ();
	sjjl_cfg_if cfg_ch ();

	servo_joint_jog_limiter u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	logic        stick_sel = RST_STICK_MODE;
	logic        pos_cw    = RST_POS_IS_CW;
	logic [14:0] dz_lim    = RST_DEAD_ZONE;
	logic [7:0]  ang_lo    = RST_ANGLE_MIN;
	logic [7:0]  ang_hi    = RST_ANGLE_MAX;
	logic [7:0]  step_deg  = RST_STEP_SIZE;
	logic [7:0]  joint     = RST_START_ANGLE;

	rsp_t due_results[$];
	int   mismatches = 0;
	int   quiet_cycles = 0;
	bit   gaps_on = 1'b1;
	bit   stalls_on = 1'b1;
	bit   hold_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic dir_t jog_dir(cmd_t c);
		int v;
		if (stick_sel) begin
			v = int'(c.stick_value);
			if ((v < 0 ? -v : v) <= int'(dz_lim))
				return DIR_NONE;
			if ((v < 0) == pos_cw)
				return DIR_CCW;
			return DIR_CW;
		end
		if (c.cw_button && !c.ccw_button)
			return DIR_CW;
		if (c.ccw_button && !c.cw_button)
			return DIR_CCW;
		return DIR_NONE;
	endfunction

	function automatic rsp_t step_joint(cmd_t c);
		int   old;
		int   nxt;
		int   amt;
		int   lo;
		int   hi;
		int   st;
		dir_t d;
		logic clp;
		rsp_t r;
		old = int'(joint);
		lo = int'(ang_lo);
		hi = int'(ang_hi);
		st = int'(step_deg);
		nxt = old;
		clp = 1'b0;
		d = DIR_NONE;
		if (c.action == ACT_JOG) begin
			d = jog_dir(c);
			if (d == DIR_CW) begin
				if (old + st > hi || !c.interlock_ok)
					clp = 1'b1;
				else
					nxt = old + st;
			end else if (d == DIR_CCW) begin
				if (old < lo + st || !c.interlock_ok)
					clp = 1'b1;
				else
					nxt = old - st;
			end
		end else begin
			amt = int'(c.move_angle);
			case (c.move_direction)
				DIR_CW: begin
					d = DIR_CW;
					if (old + amt < hi) begin
						nxt = old + amt;
					end else begin
						clp = 1'b1;
						if (old < hi)
							nxt = hi;
					end
				end
				DIR_CCW: begin
					d = DIR_CCW;
					if (old > lo + amt) begin
						nxt = old - amt;
					end else begin
						clp = 1'b1;
						if (old > lo)
							nxt = lo;
					end
				end
				default: d = DIR_NONE;
			endcase
		end
		joint = nxt[7:0];
		r.position = joint;
		r.moved = (joint != old[7:0]);
		r.direction_taken = d;
		r.clamped = clp;
		return r;
	endfunction

	function automatic void apply_reg(reg_idx_t idx, logic [14:0] val);
		case (idx)
			REG_STICK_MODE:  stick_sel = val[0];
			REG_POS_IS_CW:   pos_cw = val[0];
			REG_DEAD_ZONE:   dz_lim = val;
			REG_ANGLE_MIN:   ang_lo = val[7:0];
			REG_ANGLE_MAX:   ang_hi = val[7:0];
			REG_STEP_SIZE:   step_deg = val[7:0];
			// the DUT ignores this index; the angle resets to RST_START_ANGLE
			REG_START_ANGLE: ;
			default: ;
		endcase
	endfunction

	task automatic report(string field, int want, int got);
		$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
		mismatches++;
	endtask

	always @(posedge clk) begin : scoreboard
		cmd_t c;
		rsp_t want;
		bit   busy;
		if (arst_n) begin
			busy = 1'b0;
			if (cfg_ch.valid && cfg_ch.ready) begin
				apply_reg(reg_idx_t'(cfg_ch.reg_index), cfg_ch.wdata);
				busy = 1'b1;
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				c.action = cmd_ch.action;
				c.stick_value = cmd_ch.stick_value;
				c.cw_button = cmd_ch.cw_button;
				c.ccw_button = cmd_ch.ccw_button;
				c.move_direction = cmd_ch.move_direction;
				c.move_angle = cmd_ch.move_angle;
				c.interlock_ok = cmd_ch.interlock_ok;
				due_results.push_back(step_joint(c));
				busy = 1'b1;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				busy = 1'b1;
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result position %0d", $time, rsp_ch.position);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					if (rsp_ch.position !== want.position)
						report("position", int'(want.position), int'(rsp_ch.position));
					if (rsp_ch.moved !== want.moved)
						report("moved", int'(want.moved), int'(rsp_ch.moved));
					if (rsp_ch.direction_taken !== want.direction_taken)
						report("direction_taken", int'(want.direction_taken),
							int'(rsp_ch.direction_taken));
					if (rsp_ch.clamped !== want.clamped)
						report("clamped", int'(want.clamped), int'(rsp_ch.clamped));
				end
			end
			quiet_cycles = busy ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
				$display("servo_joint_jog_limiter_test NOT OK");
				$finish;
			end
		end
	end

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (stalls_on && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(0, 18)) @(negedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_cmd(cmd_t c);
		int gap;
		gap = (gaps_on && $urandom_range(0, 5) == 0) ? int'($urandom_range(1, 19)) : 0;
		@(negedge clk);
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.action <= c.action;
		cmd_ch.stick_value <= c.stick_value;
		cmd_ch.cw_button <= c.cw_button;
		cmd_ch.ccw_button <= c.ccw_button;
		cmd_ch.move_direction <= c.move_direction;
		cmd_ch.move_angle <= c.move_angle;
		cmd_ch.interlock_ok <= c.interlock_ok;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(reg_idx_t idx, logic [14:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wdata <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic configure(logic sm, logic pcw, logic [14:0] dz, logic [7:0] lo,
		logic [7:0] hi, logic [7:0] st);
		wait_idle();
		set_reg(REG_STICK_MODE, {14'd0, sm});
		set_reg(REG_POS_IS_CW, {14'd0, pcw});
		set_reg(REG_DEAD_ZONE, dz);
		set_reg(REG_ANGLE_MIN, {7'd0, lo});
		set_reg(REG_ANGLE_MAX, {7'd0, hi});
		set_reg(REG_STEP_SIZE, {7'd0, st});
	endtask

	function automatic cmd_t button_jog(logic cw, logic ccw, logic ilk);
		cmd_t c;
		c = '0;
		c.action = ACT_JOG;
		c.cw_button = cw;
		c.ccw_button = ccw;
		c.interlock_ok = ilk;
		return c;
	endfunction

	function automatic cmd_t stick_jog(int v);
		cmd_t c;
		c = '0;
		c.action = ACT_JOG;
		c.stick_value = v[15:0];
		c.interlock_ok = 1'b1;
		return c;
	endfunction

	function automatic cmd_t move_by(logic [1:0] d, int ang);
		cmd_t c;
		c = '0;
		c.action = ACT_MOVE;
		c.move_direction = d;
		c.move_angle = ang[7:0];
		c.interlock_ok = 1'b1;
		return c;
	endfunction

	function automatic cmd_t random_command();
		cmd_t c;
		int   v;
		c.action = ($urandom_range(0, 2) == 0) ? ACT_MOVE : ACT_JOG;
		case ($urandom_range(0, 4))
			0: begin
				v = int'(dz_lim) + int'($urandom_range(0, 2)) - 1;
				if ($urandom_range(0, 1) != 0)
					v = -v;
			end
			1: v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
			default: v = int'($urandom_range(0, 65535)) - 32768;
		endcase
		c.stick_value = v[15:0];
		c.cw_button = 1'($urandom_range(0, 1));
		c.ccw_button = 1'($urandom_range(0, 1));
		c.move_direction = 2'($urandom_range(0, 3));
		c.move_angle = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 60));
		c.interlock_ok = ($urandom_range(0, 7) != 0);
		return c;
	endfunction

	task automatic test_button_jog();
		send_cmd(button_jog(1'b1, 1'b0, 1'b1));
		send_cmd(button_jog(1'b0, 1'b1, 1'b1));
		send_cmd(button_jog(1'b1, 1'b1, 1'b1));
		send_cmd(button_jog(1'b0, 1'b0, 1'b1));
		send_cmd(button_jog(1'b1, 1'b0, 1'b0));
	endtask

	task automatic test_stick_dead_zone();
		configure(1'b1, 1'b1, 15'd7500, 8'd0, 8'd180, 8'd5);
		send_cmd(stick_jog(7500));
		send_cmd(stick_jog(-7500));
		send_cmd(stick_jog(7501));
		send_cmd(stick_jog(-7501));
		send_cmd(stick_jog(32767));
		send_cmd(stick_jog(-32768));
		configure(1'b1, 1'b0, 15'd32767, 8'd0, 8'd180, 8'd5);
		send_cmd(stick_jog(32767));
		send_cmd(stick_jog(-32768));
		send_cmd(stick_jog(0));
	endtask

	task automatic test_move_clamp();
		configure(1'b0, 1'b1, 15'd7500, 8'd0, 8'd180, 8'd5);
		send_cmd(move_by(DIR_CW, 255));
		send_cmd(move_by(DIR_CW, 0));
		send_cmd(move_by(DIR_CCW, 100));
		send_cmd(move_by(DIR_CCW, 180));
		send_cmd(move_by(DIR_CCW, 0));
		send_cmd(move_by(DIR_NONE, 50));
		send_cmd(move_by(DIR_CODE_INVALID, 50));
		send_cmd(button_jog(1'b0, 1'b1, 1'b1));
	endtask

	task automatic test_odd_limits();
		configure(1'b0, 1'b1, 15'd7500, 8'd100, 8'd20, 8'd0);
		set_reg(REG_START_ANGLE, 15'd17);
		send_cmd(button_jog(1'b1, 1'b0, 1'b1));
		send_cmd(move_by(DIR_CW, 10));
		send_cmd(move_by(DIR_CCW, 5));
		configure(1'b0, 1'b1, 15'd7500, 8'd0, 8'd255, 8'd180);
		send_cmd(button_jog(1'b1, 1'b0, 1'b1));
		send_cmd(button_jog(1'b1, 1'b0, 1'b1));
		send_cmd(move_by(DIR_CW, 255));
	endtask

	task automatic test_random_phases();
		logic [14:0] dz;
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic [7:0]  st;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(0, 3))
				0: dz = 15'd0;
				1: dz = 15'd32767;
				default: dz = 15'($urandom_range(0, 32767));
			endcase
			if (phase == 0) begin
				lo = 8'd0;
				hi = 8'd180;
			end else if ($urandom_range(0, 4) == 0) begin
				lo = 8'($urandom_range(0, 255));
				hi = 8'($urandom_range(0, 255));
			end else begin
				lo = 8'($urandom_range(0, 90));
				hi = 8'($urandom_range(32'(lo), 180));
			end
			case ($urandom_range(0, 5))
				0: st = 8'd0;
				1: st = 8'd180;
				default: st = 8'($urandom_range(1, 20));
			endcase
			configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), dz, lo, hi, st);
			repeat (PHASE_ITEMS) send_cmd(random_command());
		end
	endtask

	task automatic test_backpressure();
		configure(1'b1, 1'b1, 15'd2000, 8'd10, 8'd170, 8'd3);
		gaps_on = 1'b0;
		hold_req = 1'b1;
		repeat (30) send_cmd(random_command());
		wait_idle();
		gaps_on = 1'b1;
	endtask

	task automatic test_steady_stream();
		configure(1'b0, 1'b1, 15'd7500, 8'd0, 8'd180, 8'd7);
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		repeat (120) send_cmd(random_command());
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.action = ACT_JOG;
		cmd_ch.stick_value = '0;
		cmd_ch.cw_button = 1'b0;
		cmd_ch.ccw_button = 1'b0;
		cmd_ch.move_direction = DIR_NONE;
		cmd_ch.move_angle = '0;
		cmd_ch.interlock_ok = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.reg_index = REG_STICK_MODE;
		cfg_ch.wdata = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_button_jog();
		test_stick_dead_zone();
		test_move_clamp();
		test_odd_limits();
		test_random_phases();
		test_backpressure();
		test_steady_stream();
		wait_idle();

		if (mismatches == 0)
			$display("servo_joint_jog_limiter_test OK");
		else
			$display("servo_joint_jog_limiter_test NOT OK");
		$finish;
	end

endmodule
